>>> hdl/szr_pkg.sv
`default_nettype none
package szr_pkg;

  localparam logic [31:0] ZipMagic   = 32'h04034b50;
  localparam logic [4:0]  HdrLen     = 5'd30;
  localparam logic [4:0]  OffMethod  = 5'd8;
  localparam logic [4:0]  OffSize    = 5'd18;
  localparam logic [4:0]  OffName    = 5'd26;
  localparam logic [4:0]  OffExtra   = 5'd28;
  localparam logic [15:0] MaxEntriesReset = 16'd1024;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_NAME    = 3'd1,
    PH_EXTRA   = 3'd2,
    PH_DATA    = 3'd3,
    PH_STOPPED = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    FAIL_NONE       = 2'd0,
    FAIL_COMPRESSED = 2'd1,
    FAIL_TOO_MANY   = 2'd2
  } fail_e;

  typedef enum logic [1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_TRUNCATED  = 3'd2,
    ST_COMPRESSED = 3'd3,
    ST_TOO_MANY   = 3'd4
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  header_pos;
    logic [31:0] signature_word;
    logic [15:0] method_word;
    logic [31:0] entry_size;
    logic [15:0] name_length;
    logic [15:0] extra_length;
    logic [31:0] bytes_left;
    logic [15:0] entries_seen;
    fail_e       pending_fail;
  } parse_state_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [15:0] entry_index;
    logic        done;
    status_e     status;
    logic [15:0] entry_total;
  } result_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] bytes_left;
  } section_t;

  localparam parse_state_t StateReset = '{
    phase:          PH_HEADER,
    header_pos:     5'd0,
    signature_word: 32'd0,
    method_word:    16'd0,
    entry_size:     32'd0,
    name_length:    16'd0,
    extra_length:   16'd0,
    bytes_left:     32'd0,
    entries_seen:   16'd0,
    pending_fail:   FAIL_NONE
  };

  // first non-empty section at or after 'from'; otherwise the entry closes
  function automatic section_t enter_section(input phase_e      from,
                                             input logic [15:0] name_len,
                                             input logic [15:0] extra_len,
                                             input logic [31:0] size,
                                             input fail_e       pending,
                                             input logic [31:0] cur_left);
    section_t s;
    s.bytes_left = cur_left;
    if (from <= PH_NAME && name_len != 16'd0) begin
      s.phase      = PH_NAME;
      s.bytes_left = {16'd0, name_len};
    end else if (from <= PH_EXTRA && extra_len != 16'd0) begin
      s.phase      = PH_EXTRA;
      s.bytes_left = {16'd0, extra_len};
    end else if (from <= PH_DATA && size != 32'd0) begin
      s.phase      = PH_DATA;
      s.bytes_left = size;
    end else begin
      s.phase = (pending != FAIL_NONE) ? PH_STOPPED : PH_HEADER;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hdl/stored_zip_reader_core.sv
// Stored zip reader: parses the local headers of an archive of stored entries.
// Input stream: one archive byte per request on s_axis_tdata, s_axis_tlast on
// the last byte of the archive. Output stream: one result per request that
// produces one; kind on m_axis_tuser (entry header, name byte, data byte or
// status only), value, entry index, status and entry total on m_axis_tdata, m_axis_tlast
// on the result of the last archive byte, which always appears and carries the final
// status. Otherwise extra bytes, and header bytes but an accepted header's last, give none.
// The config channel writes max_entries (16 bits, 1024 after reset); write it
// only between archives. cfg_ready_o is always high.
// Throughput: one byte per cycle while s_axis_tready is high. The parser state
// advances in the same cycle a byte is taken; its result sits in the output
// register the next cycle. s_axis_tready follows the output register: it stays
// high while that register is empty or is being drained, and drops while the
// receiver stalls with a result held.
// Reset clears the parser and the output valid flag and restores max_entries.
// After the last archive byte the parser returns to its reset state.
`default_nettype none
module stored_zip_reader_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,     // max_entries
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  wire logic        s_axis_tlast,   // final_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [31:0] value, [47:32] entry_index,
                                           // [50:48] status, [66:51] entry_total,
                                           // [71:67] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // done_res
);
  import szr_pkg::*;

  parse_state_t st_q, st_d;
  logic [15:0]  max_entries_q;
  logic         emit;
  result_t      step_res;
  result_t      out_res;
  logic         s_fire;

  assign cfg_ready_o = 1'b1;
  assign s_fire      = s_axis_tvalid && s_axis_tready;

  szr_step u_step (
    .st_i          (st_q),
    .byte_i        (s_axis_tdata),
    .final_i       (s_axis_tlast),
    .max_entries_i (max_entries_q),
    .st_o          (st_d),
    .emit_o        (emit),
    .res_o         (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= StateReset;
      max_entries_q <= MaxEntriesReset;
    end else begin
      if (s_fire) begin
        st_q <= st_d;
      end
      if (cfg_valid_i) begin
        max_entries_q <= cfg_data_i;
      end
    end
  end

  szr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && emit),
    .in_ready_o  (s_axis_tready),
    .in_res_i    (step_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.entry_total, out_res.status,
                         out_res.entry_index, out_res.value};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.done;

  a_final_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast |=> st_q.phase == PH_HEADER && st_q.entries_seen == 16'd0
                               && st_q.pending_fail == FAIL_NONE)
    else $error("parser not cleared after last byte");

  a_final_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("last byte gave no final result");

  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_STATUS |-> m_axis_tlast)
    else $error("status-only result without done");

  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase != PH_HEADER |-> st_q.header_pos == 5'd0)
    else $error("header position left nonzero outside header");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.header_pos < HdrLen)
    else $error("header position out of range");

endmodule
`default_nettype wire

>>> hdl/szr_step.sv
`default_nettype none
module szr_step (
  input  wire szr_pkg::parse_state_t st_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             final_i,
  input  wire logic [15:0]      max_entries_i,
  output szr_pkg::parse_state_t st_o,
  output logic                  emit_o,
  output szr_pkg::result_t      res_o
);
  import szr_pkg::*;

  parse_state_t nxt;
  result_t      res;
  logic         emit;
  logic [4:0]   p;
  logic [4:0]   pos_inc;
  logic [4:0]   lane;
  section_t     sect;
  phase_e       after;

  always_comb begin
    nxt     = st_i;
    emit    = 1'b0;
    res     = '0;
    res.kind   = KIND_STATUS;
    res.status = ST_OK;
    p       = st_i.header_pos;
    pos_inc = p + 5'd1;
    lane    = 5'd0;
    sect    = '{phase: st_i.phase, bytes_left: st_i.bytes_left};
    after   = PH_STOPPED;

    unique case (st_i.phase)
      PH_HEADER: begin
        if (p == 5'd0) begin
          nxt.signature_word = 32'd0;
          nxt.method_word    = 16'd0;
          nxt.entry_size     = 32'd0;
          nxt.name_length    = 16'd0;
          nxt.extra_length   = 16'd0;
        end
        // little-endian fields; each lane is written once per header
        if (p < 5'd4) begin
          nxt.signature_word[{p[1:0], 3'b000} +: 8] = byte_i;
        end else if (p >= OffMethod && p < OffMethod + 5'd2) begin
          lane = p - OffMethod;
          nxt.method_word[{lane[0], 3'b000} +: 8] = byte_i;
        end else if (p >= OffSize && p < OffSize + 5'd4) begin
          lane = p - OffSize;
          nxt.entry_size[{lane[1:0], 3'b000} +: 8] = byte_i;
        end else if (p >= OffName && p < OffName + 5'd2) begin
          lane = p - OffName;
          nxt.name_length[{lane[0], 3'b000} +: 8] = byte_i;
        end else if (p >= OffExtra && p < OffExtra + 5'd2) begin
          lane = p - OffExtra;
          nxt.extra_length[{lane[0], 3'b000} +: 8] = byte_i;
        end
        nxt.header_pos = pos_inc;
        if (pos_inc >= HdrLen) begin
          nxt.header_pos = 5'd0;
          if (nxt.signature_word != ZipMagic) begin
            nxt.phase = PH_STOPPED;
          end else begin
            if (nxt.method_word != 16'd0) begin
              nxt.pending_fail = FAIL_COMPRESSED;
            end else if (st_i.entries_seen >= max_entries_i) begin
              nxt.pending_fail = FAIL_TOO_MANY;
            end else begin
              emit            = 1'b1;
              res.kind        = KIND_ENTRY;
              res.value       = nxt.entry_size;
              res.entry_index = st_i.entries_seen;
              nxt.entries_seen = st_i.entries_seen + 16'd1;
            end
            sect = enter_section(PH_NAME, nxt.name_length, nxt.extra_length,
                                 nxt.entry_size, nxt.pending_fail, st_i.bytes_left);
            nxt.phase      = sect.phase;
            nxt.bytes_left = sect.bytes_left;
          end
        end
      end
      PH_NAME, PH_DATA: begin
        if (st_i.pending_fail == FAIL_NONE) begin
          emit            = 1'b1;
          res.kind        = (st_i.phase == PH_NAME) ? KIND_NAME : KIND_DATA;
          res.value       = {24'd0, byte_i};
          res.entry_index = st_i.entries_seen - 16'd1;
        end
        nxt.bytes_left = st_i.bytes_left - 32'd1;
        after = (st_i.phase == PH_NAME) ? PH_EXTRA : PH_STOPPED;
        if (st_i.bytes_left == 32'd1) begin
          sect = enter_section(after, st_i.name_length, st_i.extra_length,
                               st_i.entry_size, st_i.pending_fail, nxt.bytes_left);
          nxt.phase      = sect.phase;
          nxt.bytes_left = sect.bytes_left;
        end
      end
      PH_EXTRA: begin
        nxt.bytes_left = st_i.bytes_left - 32'd1;
        if (st_i.bytes_left == 32'd1) begin
          sect = enter_section(PH_DATA, st_i.name_length, st_i.extra_length,
                               st_i.entry_size, st_i.pending_fail, nxt.bytes_left);
          nxt.phase      = sect.phase;
          nxt.bytes_left = sect.bytes_left;
        end
      end
      default: begin
      end
    endcase

    if (final_i) begin
      res.done        = 1'b1;
      res.entry_total = nxt.entries_seen;
      // truncation first, then a refused entry, then the empty check
      if (nxt.phase == PH_NAME || nxt.phase == PH_EXTRA || nxt.phase == PH_DATA) begin
        res.status = ST_TRUNCATED;
      end else if (nxt.pending_fail == FAIL_COMPRESSED) begin
        res.status = ST_COMPRESSED;
      end else if (nxt.pending_fail == FAIL_TOO_MANY) begin
        res.status = ST_TOO_MANY;
      end else begin
        res.status = (nxt.entries_seen == 16'd0) ? ST_EMPTY : ST_OK;
      end
      nxt = StateReset;
    end
  end

  assign st_o   = nxt;
  assign emit_o = emit | final_i;
  assign res_o  = res;

endmodule
`default_nettype wire

>>> hdl/szr_out_reg.sv
`default_nettype none
module szr_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire szr_pkg::result_t in_res_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output szr_pkg::result_t      out_res_o
);
  import szr_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  // free slot, or the held result leaves this cycle
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= in_res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule
`default_nettype wire

>>> tb/sv/tb_stored_zip_reader_core.sv
`timescale 1ns / 1ps

module tb_stored_zip_reader_core;
  import szr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomBytes = 120;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  stored_zip_reader_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // parser mirror
  logic [15:0] zp_max;
  phase_e      zp_phase;
  logic [4:0]  zp_pos;
  logic [31:0] zp_sig;
  logic [15:0] zp_method;
  logic [31:0] zp_size;
  logic [15:0] zp_nlen;
  logic [15:0] zp_xlen;
  logic [31:0] zp_left;
  logic [15:0] zp_seen;
  fail_e       zp_fail;

  result_t     parse_results_q[$];
  logic [7:0]  arch_q[$];
  int          errors;
  int          bytes_taken;
  int          cycle_cnt;
  int          hold_len;
  bit          src_idle_on;
  bit          snk_idle_on;
  result_t     want_res;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_parse();
    zp_phase  = PH_HEADER;
    zp_pos    = '0;
    zp_sig    = '0;
    zp_method = '0;
    zp_size   = '0;
    zp_nlen   = '0;
    zp_xlen   = '0;
    zp_left   = '0;
    zp_seen   = '0;
    zp_fail   = FAIL_NONE;
  endfunction

  // first non-empty section at or after 'from', else the entry closes
  function automatic void open_section(phase_e from);
    if (from <= PH_NAME && zp_nlen != 16'd0) begin
      zp_phase = PH_NAME;
      zp_left  = {16'd0, zp_nlen};
    end else if (from <= PH_EXTRA && zp_xlen != 16'd0) begin
      zp_phase = PH_EXTRA;
      zp_left  = {16'd0, zp_xlen};
    end else if (from <= PH_DATA && zp_size != 32'd0) begin
      zp_phase = PH_DATA;
      zp_left  = zp_size;
    end else begin
      zp_phase = (zp_fail != FAIL_NONE) ? PH_STOPPED : PH_HEADER;
      zp_pos   = '0;
    end
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input bit fin, output result_t r);
    logic [4:0]  p;
    bit          emit;
    kind_e       k;
    logic [31:0] v;
    logic [15:0] idx;
    status_e     st;
    emit = 1'b0;
    k    = KIND_STATUS;
    v    = '0;
    idx  = '0;
    case (zp_phase)
      PH_HEADER: begin
        p = zp_pos;
        if (p == 5'd0) begin
          zp_sig    = '0;
          zp_method = '0;
          zp_size   = '0;
          zp_nlen   = '0;
          zp_xlen   = '0;
        end
        if (p < 5'd4)
          zp_sig[8*p[1:0] +: 8] = b;
        else if (p >= OffMethod && p < OffMethod + 5'd2)
          zp_method[8*(p - OffMethod) +: 8] = b;
        else if (p >= OffSize && p < OffSize + 5'd4)
          zp_size[8*(p - OffSize) +: 8] = b;
        else if (p >= OffName && p < OffName + 5'd2)
          zp_nlen[8*(p - OffName) +: 8] = b;
        else if (p >= OffExtra && p < OffExtra + 5'd2)
          zp_xlen[8*(p - OffExtra) +: 8] = b;
        zp_pos = p + 5'd1;
        if (zp_pos >= HdrLen) begin
          zp_pos = '0;
          if (zp_sig != ZipMagic) begin
            zp_phase = PH_STOPPED;
          end else begin
            // compressed wins over too many
            if (zp_method != 16'd0) begin
              zp_fail = FAIL_COMPRESSED;
            end else if (zp_seen >= zp_max) begin
              zp_fail = FAIL_TOO_MANY;
            end else begin
              emit    = 1'b1;
              k       = KIND_ENTRY;
              v       = zp_size;
              idx     = zp_seen;
              zp_seen = zp_seen + 16'd1;
            end
            open_section(PH_NAME);
          end
        end
      end
      PH_NAME, PH_DATA: begin
        // refused entries are still counted through, silently
        if (zp_fail == FAIL_NONE) begin
          emit = 1'b1;
          k    = (zp_phase == PH_NAME) ? KIND_NAME : KIND_DATA;
          v    = {24'd0, b};
          idx  = zp_seen - 16'd1;
        end
        zp_left = zp_left - 32'd1;
        if (zp_left == 32'd0)
          open_section(zp_phase == PH_NAME ? PH_EXTRA : PH_STOPPED);
      end
      PH_EXTRA: begin
        zp_left = zp_left - 32'd1;
        if (zp_left == 32'd0)
          open_section(PH_DATA);
      end
      default: ;
    endcase

    r.kind        = k;
    r.value       = v;
    r.entry_index = idx;
    r.done        = 1'b0;
    r.status      = ST_OK;
    r.entry_total = '0;
    if (fin) begin
      if (zp_phase == PH_NAME || zp_phase == PH_EXTRA || zp_phase == PH_DATA)
        st = ST_TRUNCATED;
      else if (zp_fail == FAIL_COMPRESSED)
        st = ST_COMPRESSED;
      else if (zp_fail == FAIL_TOO_MANY)
        st = ST_TOO_MANY;
      else
        st = (zp_seen == 16'd0) ? ST_EMPTY : ST_OK;
      if (!emit) begin
        r.kind        = KIND_STATUS;
        r.value       = '0;
        r.entry_index = '0;
      end
      r.done        = 1'b1;
      r.status      = st;
      r.entry_total = zp_seen;
      clear_parse();
      emit = 1'b1;
    end
    return emit;
  endfunction

  function automatic int draw_gap(bit on);
    if (!on || $urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic void add_header(logic [31:0] sig, logic [15:0] method, logic [31:0] size,
                                     logic [15:0] nlen, logic [15:0] xlen);
    int         pos;
    logic [7:0] hb;
    for (pos = 0; pos < HdrLen; pos++) begin
      hb = 8'($urandom);
      if (pos < 4)
        hb = sig[8*pos +: 8];
      else if (pos >= OffMethod && pos < OffMethod + 2)
        hb = method[8*(pos - OffMethod) +: 8];
      else if (pos >= OffSize && pos < OffSize + 4)
        hb = size[8*(pos - OffSize) +: 8];
      else if (pos >= OffName && pos < OffName + 2)
        hb = nlen[8*(pos - OffName) +: 8];
      else if (pos >= OffExtra && pos < OffExtra + 2)
        hb = xlen[8*(pos - OffExtra) +: 8];
      arch_q = {arch_q, hb};
    end
  endfunction

  function automatic void add_random(int n);
    repeat (n) arch_q = {arch_q, 8'($urandom)};
  endfunction

  function automatic void add_entry(logic [31:0] sig, logic [15:0] method, logic [31:0] size,
                                    logic [15:0] nlen, logic [15:0] xlen);
    add_header(sig, method, size, nlen, xlen);
    add_random(int'(nlen) + int'(xlen) + int'(size));
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want, got);
      errors++;
    end
  endfunction

  task automatic send_byte(logic [7:0] b, bit last);
    result_t r;
    int      gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_taken++;
    if (parse_byte(b, last, r))
      parse_results_q = {parse_results_q, r};
    gap = draw_gap(src_idle_on);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // drop valid and let every owed result drain
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_archive(int pause_at);
    int i;
    int n;
    n = arch_q.size();
    for (i = 0; i < n; i++) begin
      if (i == pause_at)
        wait_idle();
      send_byte(arch_q[i], i == n - 1);
    end
    arch_q.delete();
  endtask

  task automatic set_max_entries(logic [15:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    zp_max = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_single_archives();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    // lone final bytes: status only, no entries
    arch_q = {arch_q, 8'h00};
    send_archive(-1);
    arch_q = {arch_q, 8'hFF};
    send_archive(-1);
    // plain entry with name, extra and data
    add_entry(ZipMagic, 16'd0, 32'd4, 16'd3, 16'd2);
    send_archive(-1);
    // empty entry, then a central directory signature stops parsing
    add_entry(ZipMagic, 16'd0, 32'd0, 16'd0, 16'd0);
    add_header(32'h02014b50, 16'd0, 32'd3, 16'd1, 16'd0);
    add_random(5);
    send_archive(-1);
    // compressed entry; later bytes ignored
    add_entry(ZipMagic, 16'd8, 32'd3, 16'd2, 16'd1);
    add_entry(ZipMagic, 16'd0, 32'd1, 16'd1, 16'd1);
    send_archive(-1);
    // truncation outranks compressed
    add_header(ZipMagic, 16'hFFFF, 32'd5, 16'd0, 16'd0);
    add_random(2);
    send_archive(-1);
    // truncated in data, in name, in extra
    add_header(ZipMagic, 16'd0, 32'hFFFF_FFFF, 16'd1, 16'd0);
    add_random(4);
    send_archive(-1);
    add_header(ZipMagic, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF);
    add_random(3);
    send_archive(-1);
    add_header(ZipMagic, 16'd0, 32'd5, 16'd0, 16'd4);
    add_random(2);
    send_archive(-1);
    // last byte completes a header
    add_header(ZipMagic, 16'd0, 32'd0, 16'd0, 16'd0);
    send_archive(-1);
    add_header(ZipMagic, 16'd0, 32'd7, 16'd0, 16'd0);
    send_archive(-1);
    // short tail after a full entry
    add_entry(ZipMagic, 16'd0, 32'd1, 16'd1, 16'd0);
    add_random(10);
    send_archive(-1);
    // bad signature up front
    add_header(ZipMagic ^ 32'h8000_0000, 16'd0, 32'd1, 16'd0, 16'd0);
    add_random(1);
    send_archive(-1);
  endtask

  task automatic test_entry_limit();
    set_max_entries(16'd1);
    add_entry(ZipMagic, 16'd0, 32'd1, 16'd0, 16'd0);
    add_entry(ZipMagic, 16'd0, 32'd2, 16'd1, 16'd1);
    add_random(2);
    send_archive(-1);
    // over the limit and compressed at once
    add_entry(ZipMagic, 16'd0, 32'd1, 16'd0, 16'd0);
    add_entry(ZipMagic, 16'd1, 32'd1, 16'd0, 16'd0);
    send_archive(-1);
    // refused entry cut short
    add_entry(ZipMagic, 16'd0, 32'd1, 16'd0, 16'd0);
    add_header(ZipMagic, 16'd0, 32'd9, 16'd2, 16'd0);
    add_random(4);
    send_archive(-1);
    set_max_entries(16'hFFFF);
    repeat (2) add_entry(ZipMagic, 16'd0, 32'd1, 16'd1, 16'd0);
    send_archive(-1);
  endtask

  task automatic test_backpressure();
    set_max_entries(16'd1024);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    add_entry(ZipMagic, 16'd0, 32'd20, 16'd4, 16'd0);
    // long receiver stall fills the output and stalls the input; mid-archive
    // the source drains everything before going on
    hold_len = 300;
    send_archive(40);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  task automatic test_random_archives();
    int start;
    int n;
    int cut;
    logic [31:0] sig;
    logic [15:0] method;
    logic [31:0] size;
    start = bytes_taken;
    while (bytes_taken - start < RandomBytes) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: set_max_entries(16'd1);
          1: set_max_entries(16'd2);
          2: set_max_entries(16'hFFFF);
          3: set_max_entries(16'($urandom_range(1, 65535)));
          default: set_max_entries(16'($urandom_range(1, 6)));
        endcase
      end
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        add_random($urandom_range(1, 40));
      end else begin
        n = $urandom_range(0, 4);
        repeat (n) begin
          sig = ZipMagic;
          if ($urandom_range(0, 15) == 0)
            sig = ($urandom_range(0, 1) == 0) ? ZipMagic ^ (32'd1 << $urandom_range(0, 31))
                                               : 32'($urandom);
          method = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'd0;
          size = ($urandom_range(0, 4) == 0) ? 32'($urandom_range(13, 64))
                                             : 32'($urandom_range(0, 12));
          add_entry(sig, method, size, 16'($urandom_range(0, 6)),
                    ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
        end
        case ($urandom_range(0, 3))
          1: add_random($urandom_range(1, 29));
          2: begin
            if (arch_q.size() > 1) begin
              cut = $urandom_range(1, arch_q.size() - 1);
              while (arch_q.size() > cut) void'(arch_q.pop_back());
            end
          end
          default: ;
        endcase
      end
      if (arch_q.size() == 0)
        add_random(1);
      send_archive(-1);
    end
  endtask

  // result sink: random stalls per result, or one long hold on request
  initial begin
    int n;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end else begin
        n = draw_gap(snk_idle_on);
      end
      if (n > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (parse_results_q.size() == 0) begin
        $error("result with nothing expected: kind %0d value 0x%0h",
               m_axis_tuser, m_axis_tdata[31:0]);
        errors++;
      end else begin
        want_res = parse_results_q.pop_front();
        check_field("kind", 32'(want_res.kind), 32'(m_axis_tuser));
        check_field("value", want_res.value, m_axis_tdata[31:0]);
        check_field("entry_index", 32'(want_res.entry_index), 32'(m_axis_tdata[47:32]));
        check_field("done", 32'(want_res.done), 32'(m_axis_tlast));
        check_field("status", 32'(want_res.status), 32'(m_axis_tdata[50:48]));
        check_field("entry_total", 32'(want_res.entry_total), 32'(m_axis_tdata[66:51]));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL stored_zip_reader_core");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    errors        = 0;
    bytes_taken   = 0;
    hold_len      = 0;
    src_idle_on   = 1'b1;
    snk_idle_on   = 1'b1;
    zp_max        = MaxEntriesReset;
    clear_parse();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_archives();
    test_entry_limit();
    test_backpressure();
    test_random_archives();

    wait_idle();
    repeat (6) @(posedge clk_i);
    if (errors == 0 && parse_results_q.size() == 0)
      $display("PASS stored_zip_reader_core");
    else
      $display("FAIL stored_zip_reader_core");
    $finish;
  end

endmodule
